@@ rtl/wsd_pkg.sv @@
`timescale 1ns / 1ps

package wsd_pkg;

  localparam int unsigned PAYLOAD_COUNT_BITS = 24;
  localparam int unsigned MAX_LEN_W = 24;
  localparam int unsigned CMP_W =
    (PAYLOAD_COUNT_BITS > MAX_LEN_W) ? PAYLOAD_COUNT_BITS : MAX_LEN_W;

  localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(1 << 20);

  localparam logic [7:0] FIN_MASK    = 8'h80;
  localparam logic [7:0] RSV_MASK    = 8'h70;
  localparam logic [7:0] OPCODE_MASK = 8'h0F;
  localparam logic [7:0] LEN7_MASK   = 8'h7F;
  localparam logic [6:0] LEN7_EXT16  = 7'd126;
  localparam logic [6:0] LEN7_EXT64  = 7'd127;

  localparam logic [2:0] EXT16_BYTES = 3'd2;
  // Eight bytes wrap to zero in the three-bit counter; the countdown still runs over eight length bytes.
  localparam logic [2:0] EXT64_BYTES = 3'd0;
  localparam logic [2:0] KEY_LAST    = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXTLEN,
    PH_KEY,
    PH_PAYLOAD,
    PH_ERROR
  } phase_e;

  typedef enum logic [2:0] {
    KIND_DATA     = 3'd0,
    KIND_EMPTY    = 3'd1,
    KIND_RSV      = 3'd2,
    KIND_UNMASKED = 3'd3,
    KIND_TOOLONG  = 3'd4
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        final_fragment;
    logic [3:0]  frame_opcode;
  } result_t;

  function automatic logic len_too_long(
    input logic [PAYLOAD_COUNT_BITS-1:0] len,
    input logic                          ovf,
    input logic [MAX_LEN_W-1:0]          max_len
  );
    logic [CMP_W-1:0] l;
    logic [CMP_W-1:0] m;
    l = CMP_W'(len);
    m = CMP_W'(max_len);
    return ovf || (l > m);
  endfunction

endpackage

@@ rtl/wsd_in_if.sv @@
`timescale 1ns / 1ps

interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

@@ rtl/wsd_out_if.sv @@
`timescale 1ns / 1ps

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] payload_byte;
  logic       last_of_frame;
  logic       final_fragment;
  logic [3:0] frame_opcode;

  modport source (output valid, output kind, output payload_byte, output last_of_frame,
                  output final_fragment, output frame_opcode, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last_of_frame,
                  input final_fragment, input frame_opcode, output ready);
endinterface

@@ rtl/websocket_frame_deframer.sv @@
`timescale 1ns / 1ps

// Client-to-server WebSocket deframer taking one stream byte per beat. Each byte
// passes through an input register, a combinational header and payload parser, and
// an output register, so a new byte is accepted every cycle while the output is
// drained. Header, length and key bytes give no result, each payload byte gives
// one unmasked beat, and a zero-length frame gives one empty-frame beat. Reserved
// bits, a missing mask bit or a length above cfg_wdata_i's limit give a single
// error beat, after which all bytes are consumed silently until reset. The limit
// should only be written while the block is idle.
module websocket_frame_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::MAX_LEN_W-1:0] cfg_wdata_i,
  wsd_in_if.sink                        in_i,
  wsd_out_if.source                     out_o
);
  import wsd_pkg::*;

  logic [MAX_LEN_W-1:0] max_len_q;
  logic                 byte_valid;
  logic [7:0]           byte_q;
  logic                 down_ready;
  logic                 take;
  logic                 res_valid;
  result_t              res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign take = byte_valid && down_ready;

  wsd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .take_i  (take),
    .valid_o (byte_valid),
    .byte_o  (byte_q)
  );

  wsd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (byte_q),
    .max_len_i   (max_len_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  wsd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .ready_o     (down_ready),
    .out_o       (out_o)
  );
endmodule

@@ rtl/wsd_in_stage.sv @@
`timescale 1ns / 1ps

module wsd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  wsd_in_if.sink     in_i,
  input  logic       take_i,
  output logic       valid_o,
  output logic [7:0] byte_o
);
  logic       valid_q;
  logic [7:0] byte_q;
  logic       load;

  assign in_i.ready = !valid_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.stream_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;
endmodule

@@ rtl/wsd_parser.sv @@
`timescale 1ns / 1ps

module wsd_parser (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              take_i,
  input  logic [7:0]                        byte_i,
  input  logic [wsd_pkg::MAX_LEN_W-1:0]     max_len_i,
  output logic                              res_valid_o,
  output wsd_pkg::result_t                  res_o
);
  import wsd_pkg::*;

  localparam int unsigned CW = PAYLOAD_COUNT_BITS;

  phase_e          phase_q, phase_d;
  logic            fin_q, fin_d;
  logic [3:0]      op_q, op_d;
  logic [CW-1:0]   len_q, len_d;
  logic            ovf_q, ovf_d;
  logic [2:0]      cnt_q, cnt_d;
  logic [CW-1:0]   rem_q, rem_d;
  logic [1:0]      midx_q, midx_d;
  logic [7:0]      key_q [4];
  logic            key_we;
  logic [CW+7:0]   shifted;
  logic            res_valid;
  result_t         res;

  always_comb begin
    phase_d   = phase_q;
    fin_d     = fin_q;
    op_d      = op_q;
    len_d     = len_q;
    ovf_d     = ovf_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    midx_d    = midx_q;
    key_we    = 1'b0;
    res_valid = 1'b0;
    shifted   = {len_q, byte_i};
    res.kind           = KIND_DATA;
    res.payload_byte   = 8'h00;
    res.last_of_frame  = 1'b0;
    res.final_fragment = fin_q;
    res.frame_opcode   = op_q;

    unique case (phase_q)
      PH_HDR0: begin
        fin_d = |(byte_i & FIN_MASK);
        op_d  = byte_i[3:0] & OPCODE_MASK[3:0];
        if ((byte_i & RSV_MASK) != 8'h00) begin
          phase_d            = PH_ERROR;
          res_valid          = 1'b1;
          res.kind           = KIND_RSV;
          res.final_fragment = fin_d;
          res.frame_opcode   = op_d;
        end else begin
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if ((byte_i & FIN_MASK) == 8'h00) begin
          phase_d   = PH_ERROR;
          res_valid = 1'b1;
          res.kind  = KIND_UNMASKED;
        end else begin
          len_d = '0;
          ovf_d = 1'b0;
          if (byte_i[6:0] == LEN7_EXT16) begin
            cnt_d   = EXT16_BYTES;
            phase_d = PH_EXTLEN;
          end else if (byte_i[6:0] == LEN7_EXT64) begin
            cnt_d   = EXT64_BYTES;
            phase_d = PH_EXTLEN;
          end else begin
            len_d = CW'(byte_i & LEN7_MASK);
            if (len_too_long(len_d, 1'b0, max_len_i)) begin
              phase_d   = PH_ERROR;
              res_valid = 1'b1;
              res.kind  = KIND_TOOLONG;
            end else begin
              cnt_d   = 3'd0;
              phase_d = PH_KEY;
            end
          end
        end
      end
      PH_EXTLEN: begin
        len_d = shifted[CW-1:0];
        ovf_d = ovf_q || (shifted[CW+7:CW] != 8'h00);
        cnt_d = cnt_q - 3'd1;
        if (cnt_d == 3'd0) begin
          if (len_too_long(len_d, ovf_d, max_len_i)) begin
            phase_d   = PH_ERROR;
            res_valid = 1'b1;
            res.kind  = KIND_TOOLONG;
          end else begin
            phase_d = PH_KEY;
          end
        end
      end
      PH_KEY: begin
        key_we = 1'b1;
        cnt_d  = cnt_q + 3'd1;
        if (cnt_q == KEY_LAST) begin
          cnt_d  = 3'd0;
          midx_d = 2'd0;
          if (len_q == '0) begin
            phase_d           = PH_HDR0;
            res_valid         = 1'b1;
            res.kind          = KIND_EMPTY;
            res.last_of_frame = 1'b1;
          end else begin
            rem_d   = len_q;
            phase_d = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        midx_d            = midx_q + 2'd1;
        rem_d             = rem_q - CW'(1);
        res_valid         = 1'b1;
        res.payload_byte  = byte_i ^ key_q[midx_q];
        res.last_of_frame = (rem_d == '0);
        if (rem_d == '0) begin
          phase_d = PH_HDR0;
        end
      end
      PH_ERROR: begin
        res_valid = 1'b0;
      end
      default: begin
        phase_d = PH_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
    end else if (take_i) begin
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_q  <= 1'b0;
      op_q   <= 4'd0;
      len_q  <= '0;
      ovf_q  <= 1'b0;
      cnt_q  <= 3'd0;
      rem_q  <= '0;
      midx_q <= 2'd0;
    end else if (take_i) begin
      fin_q  <= fin_d;
      op_q   <= op_d;
      len_q  <= len_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      midx_q <= midx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && key_we) begin
      key_q[cnt_q[1:0]] <= byte_i;
    end
  end

  assign res_valid_o = take_i && res_valid;
  assign res_o       = res;
endmodule

@@ rtl/wsd_out_stage.sv @@
`timescale 1ns / 1ps

module wsd_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  wsd_pkg::result_t res_i,
  output logic             ready_o,
  wsd_out_if.source        out_o
);
  import wsd_pkg::*;

  logic    valid_q;
  result_t res_q;

  assign ready_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid          = valid_q;
  assign out_o.kind           = res_q.kind;
  assign out_o.payload_byte   = res_q.payload_byte;
  assign out_o.last_of_frame  = res_q.last_of_frame;
  assign out_o.final_fragment = res_q.final_fragment;
  assign out_o.frame_opcode   = res_q.frame_opcode;
endmodule

@@ sim/websocket_frame_deframer_tb.sv @@
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam int unsigned HALF_PERIOD   = 4;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_ITEMS  = 1200;
  localparam int unsigned RANDOM_STAGES = 5;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam logic [63:0] COUNT_LIMIT   = (64'd1 << PAYLOAD_COUNT_BITS) - 64'd1;
  localparam logic [MAX_LEN_W-1:0] MAX_LEN_TOP = '1;

  typedef enum int unsigned {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_e;
  typedef enum int unsigned {ERR_RSV, ERR_UNMASKED, ERR_TOOLONG} err_case_e;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [MAX_LEN_W-1:0] cfg_wdata;

  wsd_in_if  in_bus();
  wsd_out_if out_bus();

  websocket_frame_deframer DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus.sink),
    .out_o       (out_bus.source)
  );

  always #(HALF_PERIOD) clk = ~clk;

  phase_e                        frame_phase;
  logic                          fin_bit;
  logic [3:0]                    opcode_bits;
  logic [63:0]                   length_acc;
  int unsigned                   hdr_left;
  logic [7:0]                    key_bytes [4];
  logic [PAYLOAD_COUNT_BITS-1:0] bytes_left;
  logic [1:0]                    key_pos;
  logic [MAX_LEN_W-1:0]          len_limit;

  result_t     parsed_beats [$];
  int unsigned mismatch_count;
  int unsigned sent_items;
  int unsigned rx_hold_cycles;
  bit          steady_flow;

  function automatic void push_beat(kind_e k, logic [7:0] data, logic last);
    result_t r;
    r.kind           = k;
    r.payload_byte   = data;
    r.last_of_frame  = last;
    r.final_fragment = fin_bit;
    r.frame_opcode   = opcode_bits;
    parsed_beats = {parsed_beats, r};
  endfunction

  function automatic void close_length();
    if (length_acc > 64'(len_limit) || length_acc > COUNT_LIMIT) begin
      frame_phase = PH_ERROR;
      push_beat(KIND_TOOLONG, 8'h00, 1'b0);
    end else begin
      hdr_left    = 0;
      frame_phase = PH_KEY;
    end
  endfunction

  function automatic void parse_stream_byte(logic [7:0] b);
    logic [7:0] plain;
    case (frame_phase)
      PH_HDR0: begin
        fin_bit     = |(b & FIN_MASK);
        opcode_bits = 4'(b & OPCODE_MASK);
        if ((b & RSV_MASK) != 8'h00) begin
          frame_phase = PH_ERROR;
          push_beat(KIND_RSV, 8'h00, 1'b0);
        end else begin
          frame_phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        if (!b[7]) begin
          frame_phase = PH_ERROR;
          push_beat(KIND_UNMASKED, 8'h00, 1'b0);
        end else begin
          length_acc = '0;
          if (b[6:0] == LEN7_EXT16) begin
            hdr_left    = 2;
            frame_phase = PH_EXTLEN;
          end else if (b[6:0] == LEN7_EXT64) begin
            hdr_left    = 8;
            frame_phase = PH_EXTLEN;
          end else begin
            length_acc = 64'(b & LEN7_MASK);
            close_length();
          end
        end
      end
      PH_EXTLEN: begin
        length_acc = {length_acc[55:0], b};
        hdr_left--;
        if (hdr_left == 0) close_length();
      end
      PH_KEY: begin
        key_bytes[hdr_left] = b;
        hdr_left++;
        if (hdr_left == 4) begin
          hdr_left = 0;
          key_pos  = '0;
          if (length_acc == 64'd0) begin
            frame_phase = PH_HDR0;
            push_beat(KIND_EMPTY, 8'h00, 1'b1);
          end else begin
            bytes_left  = length_acc[PAYLOAD_COUNT_BITS-1:0];
            frame_phase = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        plain = b ^ key_bytes[key_pos];
        key_pos++;
        bytes_left--;
        if (bytes_left == '0) frame_phase = PH_HDR0;
        push_beat(KIND_DATA, plain, bytes_left == '0);
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_mismatch(string field, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT)
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.stream_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    parse_stream_byte(b);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_length(input len_form_e form, input logic [63:0] len);
    int i;
    case (form)
      LEN_SHORT: send_byte({1'b1, len[6:0]});
      LEN_EXT16: begin
        send_byte({1'b1, LEN7_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      default: begin
        send_byte({1'b1, LEN7_EXT64});
        for (i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
      end
    endcase
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] opc, input int unsigned len,
                            input len_form_e form);
    logic [31:0] key;
    int unsigned i;
    key = $urandom;
    send_byte({fin, 3'b000, opc});
    send_length(form, 64'(len));
    for (i = 0; i < 4; i++) send_byte(key[31 - 8*i -: 8]);
    for (i = 0; i < len; i++) send_byte(8'($urandom));
  endtask

  task automatic send_random_frame();
    int unsigned len;
    int unsigned r;
    len_form_e   form;
    r = $urandom_range(0, 99);
    if (r < 15) len = 0;
    else if (r < 65) len = $urandom_range(1, 8);
    else if (r < 93) len = $urandom_range(9, 40);
    else len = $urandom_range(100, 300);
    if (len_limit <= 300 && $urandom_range(0, 9) == 0) len = len_limit;
    if (len > len_limit) len = len_limit;
    r = $urandom_range(0, 9);
    if (len > 125 || r >= 6) form = (r % 2 == 0) ? LEN_EXT16 : LEN_EXT64;
    else form = LEN_SHORT;
    send_frame(1'($urandom), 4'($urandom), len, form);
  endtask

  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (parsed_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_limit(input logic [MAX_LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    len_limit  = value;
  endtask

  task automatic test_directed();
    logic [7:0] seq [$];
    seq = '{8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00,
            8'h8F, 8'hFE, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
            8'h81, 8'h82, 8'h12, 8'h34, 8'h56, 8'h78, 8'hFF, 8'hA5};
    foreach (seq[i]) send_byte(seq[i]);
    wait_idle();
  endtask

  task automatic test_limit_extremes();
    int unsigned i;
    write_limit('0);
    send_frame(1'b1, 4'h9, 0, LEN_SHORT);
    send_frame(1'b0, 4'hA, 0, LEN_EXT16);
    send_frame(1'b1, 4'h1, 0, LEN_EXT64);
    wait_idle();
    write_limit(MAX_LEN_TOP);
    for (i = 0; i < 10; i++) send_random_frame();
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned stage;
    int unsigned goal;
    logic [MAX_LEN_W-1:0] lim;
    for (stage = 0; stage < RANDOM_STAGES; stage++) begin
      case (stage)
        0:       lim = MAX_LEN_RESET;
        1:       lim = MAX_LEN_W'($urandom_range(1, 40));
        2:       lim = MAX_LEN_TOP;
        3:       lim = MAX_LEN_W'($urandom_range(126, 300));
        default: lim = MAX_LEN_W'($urandom_range(300, 1 << 20));
      endcase
      write_limit(lim);
      steady_flow = (stage == 2);
      goal = sent_items + RANDOM_ITEMS / RANDOM_STAGES;
      while (sent_items < goal) send_random_frame();
      steady_flow = 1'b0;
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    write_limit(MAX_LEN_TOP);
    steady_flow    = 1'b1;
    rx_hold_cycles = HOLD_CYCLES;
    send_frame(1'b1, 4'h2, 200, LEN_EXT16);
    steady_flow = 1'b0;
    wait_idle();
  endtask

  task automatic test_error_tail();
    err_case_e   which;
    logic [63:0] bad_len;
    int unsigned lim;
    int unsigned i;
    which = err_case_e'($urandom_range(0, 2));
    case (which)
      ERR_RSV: send_byte({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
      ERR_UNMASKED: begin
        send_byte({1'($urandom), 3'b000, 4'($urandom)});
        send_byte({1'b0, 7'($urandom)});
      end
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            lim = $urandom_range(0, 124);
            write_limit(MAX_LEN_W'(lim));
            send_byte({1'($urandom), 3'b000, 4'($urandom)});
            send_length(LEN_SHORT, 64'($urandom_range(lim + 1, 125)));
          end
          1: begin
            lim = $urandom_range(0, 65534);
            write_limit(MAX_LEN_W'(lim));
            send_byte({1'($urandom), 3'b000, 4'($urandom)});
            send_length(LEN_EXT16, 64'($urandom_range(lim + 1, 65535)));
          end
          default: begin
            write_limit(MAX_LEN_TOP);
            bad_len = {$urandom, $urandom};
            bad_len[24 + $urandom_range(0, 39)] = 1'b1;
            send_byte({1'($urandom), 3'b000, 4'($urandom)});
            send_length(LEN_EXT64, bad_len);
          end
        endcase
      end
    endcase
    for (i = 0; i < 24; i++) send_byte(8'($urandom));
    wait_idle();
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left    = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles != 0) begin
        out_bus.ready <= 1'b0;
        rx_hold_cycles--;
      end else if (stall_left != 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap();
        out_bus.ready <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (parsed_beats.size() == 0) begin
        note_mismatch("unexpected beat, kind", 8'h00, 8'(out_bus.kind));
      end else begin
        want = parsed_beats.pop_front();
        if (out_bus.kind !== want.kind)
          note_mismatch("kind", 8'(want.kind), 8'(out_bus.kind));
        if (out_bus.payload_byte !== want.payload_byte)
          note_mismatch("payload_byte", want.payload_byte, out_bus.payload_byte);
        if (out_bus.last_of_frame !== want.last_of_frame)
          note_mismatch("last_of_frame", 8'(want.last_of_frame), 8'(out_bus.last_of_frame));
        if (out_bus.final_fragment !== want.final_fragment)
          note_mismatch("final_fragment", 8'(want.final_fragment), 8'(out_bus.final_fragment));
        if (out_bus.frame_opcode !== want.frame_opcode)
          note_mismatch("frame_opcode", 8'(want.frame_opcode), 8'(out_bus.frame_opcode));
      end
    end
  end

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_wdata          = MAX_LEN_RESET;
    in_bus.valid       = 1'b0;
    in_bus.stream_byte = 8'h00;
    frame_phase        = PH_HDR0;
    fin_bit            = 1'b0;
    opcode_bits        = 4'h0;
    length_acc         = '0;
    hdr_left           = 0;
    bytes_left         = '0;
    key_pos            = '0;
    len_limit          = MAX_LEN_RESET;
    mismatch_count     = 0;
    sent_items         = 0;
    rx_hold_cycles     = 0;
    steady_flow        = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_limit_extremes();
    test_random_frames();
    test_backpressure();
    test_error_tail();
    if (mismatch_count == 0 && parsed_beats.size() == 0) begin
      $display("websocket_frame_deframer: match");
    end else begin
      $display("websocket_frame_deframer: mismatch");
    end
    $finish;
  end

  initial begin
    #(64'd10_000_000);
    $display("websocket_frame_deframer: mismatch");
    $finish;
  end

endmodule
